// ===== rtl/ldtw_pkg.sv =====
// ----------------------------------------------------------------------------
// ldtw_pkg
// Shared types and constants for the two-wire LED driver refresh engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ldtw_pkg;

  localparam int DISPLAY_BYTES = 16;
  localparam int MEM_AW        = 4;
  localparam int BYTE_CW       = 5;
  localparam int PC_W          = 4;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_REFRESH = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [7:0] BYTE_AUTO_INC = 8'h40;
  localparam logic [7:0] BYTE_ADDR     = 8'hC0;
  localparam logic [7:0] BYTE_DISP_ON  = 8'h8F;

  localparam logic [1:0] TRANS_CMD  = 2'd0;
  localparam logic [1:0] TRANS_DATA = 2'd1;
  localparam logic [1:0] TRANS_LAST = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic busy_res;
    logic frame_done;
  } rsp_t;

  // one microcode word
  typedef struct packed {
    logic            clk_we;
    logic            clk_val;
    logic            dat_we;
    logic            dat_val;
    logic            dat_sr;     // data from shift register LSB, then shift
    logic            sr_first;   // load first byte of a transaction
    logic            bit_end;    // end of bit: loop on bits / bytes
    logic            trans_end;  // end of stop: loop on transactions
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic last_bit;
    logic more_bytes;
    logic last_trans;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/ldtw_dp.sv =====
// ----------------------------------------------------------------------------
// ldtw_dp
// Datapath: display memory, counters, shift register and pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module ldtw_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  ldtw_pkg::ctrl_t         ctrl,
  input  logic                    wr_en,
  input  logic [ldtw_pkg::MEM_AW-1:0] wr_idx,
  input  logic [7:0]              wr_val,
  output ldtw_pkg::stat_t         stat,
  output logic                    clock_level,
  output logic                    data_level
);
  import ldtw_pkg::*;

  logic [7:0]         mem [DISPLAY_BYTES];
  logic [1:0]         trans;
  logic [BYTE_CW-1:0] byte_cnt;
  logic [2:0]         bit_cnt;
  logic [7:0]         sr;

  logic [BYTE_CW-1:0] byte_inc;
  logic [BYTE_CW-1:0] n_bytes;
  logic [BYTE_CW-1:0] sel_cnt;
  logic [BYTE_CW-1:0] sel_m1;
  logic [7:0]         cur_byte;

  always_comb begin
    byte_inc = byte_cnt + BYTE_CW'(1);
    n_bytes  = (trans == TRANS_DATA) ? BYTE_CW'(DISPLAY_BYTES + 1) : BYTE_CW'(1);
    stat.last_bit   = (bit_cnt == 3'd7);
    stat.more_bytes = (byte_inc < n_bytes);
    stat.last_trans = (trans == TRANS_LAST);
    sel_cnt = ctrl.sr_first ? '0 : byte_inc;
    sel_m1  = sel_cnt - BYTE_CW'(1);
    case (trans)
      TRANS_CMD:  cur_byte = BYTE_AUTO_INC;
      TRANS_LAST: cur_byte = BYTE_DISP_ON;
      default: begin
        if (sel_cnt == '0) begin
          cur_byte = BYTE_ADDR;
        end else begin
          cur_byte = mem[sel_m1[MEM_AW-1:0]];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DISPLAY_BYTES; i++) begin
        mem[i] <= '0;
      end
      trans       <= '0;
      byte_cnt    <= '0;
      bit_cnt     <= '0;
      sr          <= '0;
      clock_level <= 1'b1;
      data_level  <= 1'b1;
    end else begin
      if (wr_en && ({1'b0, wr_idx} < (MEM_AW+1)'(DISPLAY_BYTES))) begin
        mem[wr_idx] <= wr_val;
      end
      if (step) begin
        if (ctrl.clk_we) begin
          clock_level <= ctrl.clk_val;
        end
        if (ctrl.dat_we) begin
          data_level <= ctrl.dat_sr ? sr[0] : ctrl.dat_val;
        end
        if (ctrl.dat_sr) begin
          sr <= {1'b0, sr[7:1]};
        end
        if (ctrl.sr_first) begin
          sr       <= cur_byte;
          byte_cnt <= '0;
          bit_cnt  <= '0;
        end
        if (ctrl.bit_end) begin
          if (stat.last_bit) begin
            bit_cnt  <= '0;
            byte_cnt <= byte_inc;
            if (stat.more_bytes) begin
              sr <= cur_byte;
            end
          end else begin
            bit_cnt <= bit_cnt + 3'd1;
          end
        end
        if (ctrl.trans_end) begin
          trans <= stat.last_trans ? 2'd0 : trans + 2'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ldtw_seq.sv =====
// ----------------------------------------------------------------------------
// ldtw_seq
// Microcode sequencer: step counter, control ROM, refresh request flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ldtw_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            acc,
  input  logic [1:0]      cmd,
  input  ldtw_pkg::stat_t stat,
  output ldtw_pkg::ctrl_t ctrl,
  output logic            step,
  output logic            busy,
  output logic            done
);
  import ldtw_pkg::*;

  // program labels
  localparam logic [PC_W-1:0] PC_START   = 4'd0;
  localparam logic [PC_W-1:0] PC_S_DATA  = 4'd1;
  localparam logic [PC_W-1:0] PC_S_WAIT  = 4'd2;
  localparam logic [PC_W-1:0] PC_S_CLK   = 4'd3;
  localparam logic [PC_W-1:0] PC_BIT     = 4'd4;
  localparam logic [PC_W-1:0] PC_B_CLKH  = 4'd5;
  localparam logic [PC_W-1:0] PC_B_WAIT  = 4'd6;
  localparam logic [PC_W-1:0] PC_B_CLKL  = 4'd7;
  localparam logic [PC_W-1:0] PC_B_END   = 4'd8;
  localparam logic [PC_W-1:0] PC_P_CLKL  = 4'd9;
  localparam logic [PC_W-1:0] PC_P_DATA  = 4'd10;
  localparam logic [PC_W-1:0] PC_P_WAIT0 = 4'd11;
  localparam logic [PC_W-1:0] PC_P_CLKH  = 4'd12;
  localparam logic [PC_W-1:0] PC_P_WAIT1 = 4'd13;
  localparam logic [PC_W-1:0] PC_P_END   = 4'd14;

  logic            pending;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_eff;
  logic            tick;
  logic            jump;
  logic            finish;

  assign tick   = acc && (cmd == CMD_TICK);
  assign step   = tick && (busy || pending);
  assign pc_eff = busy ? pc : PC_START;

  always_comb begin
    ctrl = '0;
    case (pc_eff)
      PC_START:   begin ctrl.clk_we = 1'b1; ctrl.clk_val = 1'b1; end
      PC_S_DATA:  begin ctrl.dat_we = 1'b1; ctrl.dat_val = 1'b0; end
      PC_S_WAIT:  begin end
      PC_S_CLK:   begin ctrl.clk_we = 1'b1; ctrl.sr_first = 1'b1; end
      PC_BIT:     begin ctrl.dat_we = 1'b1; ctrl.dat_sr = 1'b1; end
      PC_B_CLKH:  begin ctrl.clk_we = 1'b1; ctrl.clk_val = 1'b1; end
      PC_B_WAIT:  begin end
      PC_B_CLKL:  begin ctrl.clk_we = 1'b1; end
      PC_B_END:   begin ctrl.bit_end = 1'b1; ctrl.target = PC_BIT; end
      PC_P_CLKL:  begin ctrl.clk_we = 1'b1; end
      PC_P_DATA:  begin ctrl.dat_we = 1'b1; end
      PC_P_WAIT0: begin end
      PC_P_CLKH:  begin ctrl.clk_we = 1'b1; ctrl.clk_val = 1'b1; end
      PC_P_WAIT1: begin end
      PC_P_END: begin
        ctrl.dat_we    = 1'b1;
        ctrl.dat_val   = 1'b1;
        ctrl.trans_end = 1'b1;
        ctrl.target    = PC_START;
      end
      default: ctrl = '0;
    endcase
  end

  assign jump   = (ctrl.bit_end && (!stat.last_bit || stat.more_bytes)) ||
                  (ctrl.trans_end && !stat.last_trans);
  assign finish = ctrl.trans_end && stat.last_trans;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      pc      <= PC_START;
      busy    <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (acc) begin
        done <= step && finish;
      end
      if (acc && (cmd == CMD_REFRESH)) begin
        pending <= 1'b1;
      end
      if (step) begin
        if (!busy) begin
          pending <= 1'b0;
        end
        if (finish) begin
          busy <= 1'b0;
          pc   <= PC_START;
        end else begin
          busy <= 1'b1;
          pc   <= jump ? ctrl.target : pc_eff + PC_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/led_driver_two_wire_refresh.sv =====
// ----------------------------------------------------------------------------
// led_driver_two_wire_refresh
// Two-wire LED driver refresh engine driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Every item is handled when it is accepted; its result beat is registered and
// shows the cycle after acceptance. One item per cycle while results drain.
// A full frame takes 790 tick items (50 + 690 + 50 waveform steps).
// Reset: display memory cleared, pins high, idle, no refresh pending.
`default_nettype none

module led_driver_two_wire_refresh (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ldtw_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ldtw_pkg::rsp_t rsp
);
  import ldtw_pkg::*;

  logic  acc;
  logic  step;
  logic  busy;
  logic  done;
  logic  clock_level;
  logic  data_level;
  ctrl_t ctrl;
  stat_t stat;

  assign req_stall = rsp_valid && rsp_stall;
  assign acc       = req_valid && !req_stall;

  ldtw_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .cmd  (req.cmd),
    .stat (stat),
    .ctrl (ctrl),
    .step (step),
    .busy (busy),
    .done (done)
  );

  ldtw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ctrl        (ctrl),
    .wr_en       (acc && (req.cmd == CMD_LOAD)),
    .wr_idx      (req.byte_index),
    .wr_val      (req.byte_value),
    .stat        (stat),
    .clock_level (clock_level),
    .data_level  (data_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // state only moves on an accepted item, so it holds while stalled
  assign rsp.clock_pin  = clock_level;
  assign rsp.data_pin   = data_level;
  assign rsp.busy_res   = busy;
  assign rsp.frame_done = done;

endmodule

`default_nettype wire

// ===== rtl/ldtw_checker.sv =====
// ----------------------------------------------------------------------------
// ldtw_checker
// Port-level checks on the refresh engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ldtw_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input ldtw_pkg::rsp_t rsp
);
  import ldtw_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result beat right after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.frame_done |-> !rsp.busy_res)
    else $error("frame done while still busy");

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.busy_res |-> rsp.clock_pin && rsp.data_pin)
    else $error("bus not released while idle");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall)
    else $error("item taken while result beat stalled");

endmodule

bind led_driver_two_wire_refresh ldtw_checker u_ldtw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-wire LED driver refresh engine. A predictor
// tracks the display memory and the pin waveform sequencer and gives the pin
// levels, busy and done flags for every request beat. The bench sends
// directed beats, then random stretches of refresh traffic mixed with loads
// and noise, under random bursts of idling on both sides and one long output
// hold.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ldtw_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 390;
  localparam int FINAL_ITEMS  = 40;
  localparam int LONG_HOLD    = 48;
  localparam int QUIET_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {WAVE_IDLE, WAVE_START, WAVE_SEND, WAVE_STOP} wave_phase_e;

  class pin_scoreboard;
    logic [7:0]  seg_mem [DISPLAY_BYTES];
    logic [1:0]  trans_no;
    logic [4:0]  byte_no;
    logic [2:0]  bit_no;
    logic [2:0]  step_no;
    logic [7:0]  shreg;
    logic        clk_lvl;
    logic        dat_lvl;
    logic        pending;
    wave_phase_e phase;
    rsp_t        pins_due [$];
    int          errors;
    int          results_seen;

    function new();
      foreach (seg_mem[i]) seg_mem[i] = 8'h00;
      trans_no = TRANS_CMD;
      byte_no = '0;
      bit_no = '0;
      step_no = '0;
      shreg = '0;
      clk_lvl = 1'b1;
      dat_lvl = 1'b1;
      pending = 1'b0;
      phase = WAVE_IDLE;
      errors = 0;
      results_seen = 0;
    endfunction

    function logic [7:0] frame_byte();
      logic [3:0] slot;
      slot = 4'(byte_no - 5'd1);
      if (trans_no == TRANS_CMD) return BYTE_AUTO_INC;
      if (trans_no == TRANS_LAST) return BYTE_DISP_ON;
      if (byte_no == 5'd0) return BYTE_ADDR;
      return seg_mem[slot];
    endfunction

    function logic [4:0] bytes_in_trans();
      return (trans_no == TRANS_DATA) ? 5'(DISPLAY_BYTES + 1) : 5'd1;
    endfunction

    // one pin step of the waveform; returns 1 when the frame ends
    function bit wave_step();
      bit done;
      done = 1'b0;
      case (phase)
        WAVE_START: begin
          if (step_no == 3'd0) clk_lvl = 1'b1;
          else if (step_no == 3'd1) dat_lvl = 1'b0;
          else if (step_no == 3'd3) clk_lvl = 1'b0;
          if (step_no >= 3'd3) begin
            byte_no = '0;
            bit_no = '0;
            shreg = frame_byte();
            phase = WAVE_SEND;
            step_no = '0;
          end else begin
            step_no++;
          end
        end
        WAVE_SEND: begin
          if (step_no == 3'd0) begin
            dat_lvl = shreg[0];
            shreg = shreg >> 1;
          end else if (step_no == 3'd1) begin
            clk_lvl = 1'b1;
          end else if (step_no == 3'd3) begin
            clk_lvl = 1'b0;
          end
          if (step_no >= 3'd4) begin
            step_no = '0;
            if (bit_no == 3'd7) begin
              bit_no = '0;
              byte_no = byte_no + 5'd1;
              if (byte_no < bytes_in_trans()) shreg = frame_byte();
              else phase = WAVE_STOP;
            end else begin
              bit_no++;
            end
          end else begin
            step_no++;
          end
        end
        WAVE_STOP: begin
          if (step_no == 3'd0) clk_lvl = 1'b0;
          else if (step_no == 3'd1) dat_lvl = 1'b0;
          else if (step_no == 3'd3) clk_lvl = 1'b1;
          else if (step_no == 3'd5) dat_lvl = 1'b1;
          if (step_no >= 3'd5) begin
            step_no = '0;
            if (trans_no == TRANS_LAST) begin
              trans_no = TRANS_CMD;
              phase = WAVE_IDLE;
              done = 1'b1;
            end else begin
              trans_no++;
              phase = WAVE_START;
            end
          end else begin
            step_no++;
          end
        end
        default: ;
      endcase
      return done;
    endfunction

    function void note_input(req_t beat);
      rsp_t pins;
      bit done;
      done = 1'b0;
      case (beat.cmd)
        CMD_LOAD: begin
          if (beat.byte_index < DISPLAY_BYTES) seg_mem[beat.byte_index] = beat.byte_value;
        end
        CMD_REFRESH: pending = 1'b1;
        CMD_TICK: begin
          if (phase == WAVE_IDLE && pending) begin
            pending = 1'b0;
            trans_no = TRANS_CMD;
            byte_no = '0;
            bit_no = '0;
            phase = WAVE_START;
            step_no = '0;
          end
          if (phase != WAVE_IDLE) done = wave_step();
        end
        default: ;
      endcase
      pins.clock_pin = clk_lvl;
      pins.data_pin = dat_lvl;
      pins.busy_res = (phase != WAVE_IDLE);
      pins.frame_done = done;
      pins_due.push_back(pins);
    endfunction

    function bit active();
      return (phase != WAVE_IDLE) || pending;
    endfunction

    function int due();
      return pins_due.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= 40) $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task check_result(input rsp_t got);
      rsp_t want;
      results_seen++;
      if (pins_due.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = pins_due.pop_front();
        if (got.clock_pin !== want.clock_pin)
          report_mismatch($sformatf("clock_pin %b, want %b", got.clock_pin, want.clock_pin));
        if (got.data_pin !== want.data_pin)
          report_mismatch($sformatf("data_pin %b, want %b", got.data_pin, want.data_pin));
        if (got.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
        if (got.frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  pin_scoreboard board;
  bit idle_on;
  bit stall_on;
  bit hold_long;
  int items_sent;
  int quiet_cycles;

  led_driver_two_wire_refresh dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[led_driver_two_wire_refresh] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    rsp_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] c, input logic [3:0] idx, input logic [7:0] val);
    req_t beat;
    beat.cmd = c;
    beat.byte_index = idx;
    beat.byte_value = val;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req <= beat;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_input(beat);
    items_sent++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.due() != 0) @(posedge clk);
  endtask

  task automatic send_random(input logic [1:0] c);
    send_item(c, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  // part of a refresh: a few loads, the request, then mostly ticks
  task automatic frame_session(input int limit);
    int pick;
    int sent;
    sent = 0;
    repeat ($urandom_range(0, 4)) send_random(CMD_LOAD);
    send_random(CMD_REFRESH);
    while (board.active() && sent < limit) begin
      pick = $urandom_range(0, 3999);
      if (pick < 160) send_random(CMD_LOAD);
      else if (pick < 161) send_random(CMD_REFRESH);
      else if (pick < 190) send_random(CMD_NOP);
      else send_random(CMD_TICK);
      sent++;
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 20)) send_random(2'($urandom_range(0, 3)));
  endtask

  initial begin
    int sessions;
    int chunk;
    board = new();
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    hold_long = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, unused command, extreme loads, request and load mid-frame
    send_item(CMD_TICK, 4'd0, 8'h00);
    send_item(CMD_NOP, 4'd15, 8'hFF);
    send_item(CMD_LOAD, 4'd0, 8'hFF);
    send_item(CMD_LOAD, 4'd15, 8'h00);
    send_item(CMD_LOAD, 4'd15, 8'hA5);
    send_item(CMD_LOAD, 4'd7, 8'h5A);
    send_item(CMD_TICK, 4'd15, 8'hFF);
    send_item(CMD_REFRESH, 4'd0, 8'h00);
    send_item(CMD_TICK, 4'd0, 8'h00);
    send_item(CMD_TICK, 4'd0, 8'h00);
    send_item(CMD_REFRESH, 4'd15, 8'hFF);
    send_item(CMD_LOAD, 4'd0, 8'h00);
    send_item(CMD_TICK, 4'd0, 8'h00);
    send_item(CMD_NOP, 4'd0, 8'h00);
    send_item(CMD_TICK, 4'd0, 8'h00);

    items_sent = 0;
    sessions = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (sessions == 1) hold_long = 1'b1;
      chunk = $urandom_range(40, 120);
      if (chunk > RANDOM_ITEMS - items_sent) chunk = RANDOM_ITEMS - items_sent;
      if (sessions != 1 && $urandom_range(0, 9) < 2) noise_burst();
      else frame_session(chunk);
      sessions++;
      if (sessions == 3) drain_results();
    end

    idle_on = 1'b0;
    stall_on = 1'b0;
    frame_session(FINAL_ITEMS);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.due() == 0) begin
      $display("[led_driver_two_wire_refresh] OK");
    end else begin
      $display("[led_driver_two_wire_refresh] ERROR");
    end
    $finish;
  end

endmodule
